// File: hdl/hct_pkg.sv
// shared types and constants for the handle cookie table
`timescale 1ns / 1ps
package hct_pkg;

  localparam int COOKIE_W = 64;
  localparam int OBJECT_W = 16;
  localparam int COUNT_W  = 11;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  // one table entry: valid bit, cookie, object id (valid at the lsb)
  localparam int ENTRY_W  = 1 + COOKIE_W + OBJECT_W;

  localparam logic [COOKIE_W-1:0] COOKIE_STEP = 64'd7;
  localparam logic [COOKIE_W-1:0] SEED_RESET  = 64'd1;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_EVAL
  } ctrl_state_t;

  typedef struct packed {
    logic clr_we;
    logic accept;
    logic idx_start;
    logic fire;
    logic cfg_we;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_done;
    logic out_free;
  } dp_status_t;

endpackage

// File: hdl/hct_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module hct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/hct_bucket_rem.sv
// bucket index from a cookie: mask for power-of-two counts, else 4 bits/cycle remainder
`timescale 1ns / 1ps
module hct_bucket_rem #(
  parameter int BUCKETS = 256
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [hct_pkg::COOKIE_W-1:0]              value,
  output logic                                      done,
  output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] index
);
  import hct_pkg::*;

  localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  generate
    if (IS_POW2) begin : g_mask
      // bucket index is just the low bits, ready in the start cycle
      assign done  = start;
      assign index = value[AW-1:0] & AW'(BUCKETS - 1);
    end else begin : g_serial
      localparam int STEPS  = COOKIE_W / 4;
      localparam int CNT_W  = $clog2(STEPS);

      logic [COOKIE_W-1:0] sh;
      logic [AW:0]         rem;
      logic [AW:0]         rem_next;
      logic [CNT_W-1:0]    cnt;
      logic                busy;
      logic                done_q;

      always_comb begin
        rem_next = rem;
        for (int k = 0; k < 4; k++) begin
          rem_next = {rem_next[AW-1:0], sh[COOKIE_W-1-k]};
          if (rem_next >= (AW+1)'(BUCKETS)) begin
            rem_next = rem_next - (AW+1)'(BUCKETS);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy   <= 1'b0;
          done_q <= 1'b0;
          cnt    <= '0;
        end else begin
          done_q <= busy && (cnt == CNT_W'(STEPS - 1));
          if (start) begin
            busy <= 1'b1;
            cnt  <= '0;
          end else if (busy) begin
            cnt <= cnt + 1'b1;
            if (cnt == CNT_W'(STEPS - 1)) begin
              busy <= 1'b0;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          sh  <= value;
          rem <= '0;
        end else if (busy) begin
          sh  <= {sh[COOKIE_W-5:0], 4'b0};
          rem <= rem_next;
        end
      end

      assign done  = done_q;
      assign index = rem[AW-1:0];
    end
  endgenerate

endmodule

// File: hdl/hct_datapath.sv
// request registers, table memory, way compare and result registers
`timescale 1ns / 1ps
module hct_datapath #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  hct_pkg::ctrl_cmd_t              cmd,
  output hct_pkg::dp_status_t             sts,
  input  logic [hct_pkg::COOKIE_W-1:0]    cfg_data,
  input  logic [hct_pkg::OP_W-1:0]        opcode,
  input  logic [hct_pkg::OBJECT_W-1:0]    object_id,
  input  logic [hct_pkg::COOKIE_W-1:0]    cookie_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hct_pkg::STAT_W-1:0]      status,
  output logic [hct_pkg::COOKIE_W-1:0]    cookie_out,
  output logic [hct_pkg::OBJECT_W-1:0]    object_out,
  output logic [hct_pkg::COUNT_W-1:0]     live_count
);
  import hct_pkg::*;

  localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(BUCKETS * WAYS + 1);
  localparam int RW = WAYS * ENTRY_W;

  logic [COOKIE_W-1:0] next_cookie;
  logic [COOKIE_W-1:0] cand_sum;
  logic [COOKIE_W-1:0] cand;
  logic [COOKIE_W-1:0] key;
  logic [OP_W-1:0]     req_op;
  logic [OBJECT_W-1:0] req_obj;
  logic [COOKIE_W-1:0] req_cookie;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [AW-1:0]       row_addr;
  logic [AW-1:0]       clr_cnt;
  logic [AW-1:0]       idx;
  logic                idx_done;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [RW-1:0]       rd_row;
  logic [RW-1:0]       new_row;
  logic [RW-1:0]       wr_row;
  logic                wr_en;
  logic                hit_any;
  logic                free_any;
  logic [WW-1:0]       hit_way;
  logic [WW-1:0]       free_way;
  logic                do_write;
  logic [STAT_W-1:0]   res_status;
  logic [COOKIE_W-1:0] res_cookie;
  logic [OBJECT_W-1:0] res_obj;

  // generator step, skipping zero on wrap
  assign cand_sum = next_cookie + COOKIE_STEP;
  assign cand     = (cand_sum == '0) ? COOKIE_STEP : cand_sum;
  assign key      = (opcode == OP_INSERT) ? cand : cookie_in;

  hct_bucket_rem #(
    .BUCKETS(BUCKETS)
  ) u_rem (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.idx_start),
    .value(key),
    .done (idx_done),
    .index(idx)
  );

  assign rd_addr = idx_done ? idx : row_addr;
  assign wr_addr = cmd.clr_we ? clr_cnt : row_addr;
  assign wr_row  = cmd.clr_we ? '0 : new_row;
  assign wr_en   = cmd.clr_we || (cmd.fire && do_write);

  hct_ram #(
    .WIDTH(RW),
    .DEPTH(BUCKETS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_row),
    .raddr(rd_addr),
    .rdata(rd_row)
  );

  // way compare, lowest way wins
  always_comb begin
    logic                v;
    logic [COOKIE_W-1:0] ck;
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      v  = rd_row[w*ENTRY_W];
      ck = rd_row[w*ENTRY_W+1 +: COOKIE_W];
      if (v && (ck == req_cookie) && (req_cookie != '0)) begin
        hit_any = 1'b1;
        hit_way = WW'(w);
      end
      if (!v) begin
        free_any = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  always_comb begin
    new_row    = rd_row;
    do_write   = 1'b0;
    count_next = count;
    res_status = STAT_NOT_FOUND;
    res_cookie = req_cookie;
    res_obj    = '0;
    unique case (req_op)
      OP_INSERT: begin
        if (free_any) begin
          new_row[free_way*ENTRY_W +: ENTRY_W] = {req_obj, req_cookie, 1'b1};
          do_write   = 1'b1;
          count_next = count + 1'b1;
          res_status = STAT_OK;
        end else begin
          res_status = STAT_FULL;
          res_cookie = '0;
        end
      end
      OP_REMOVE: begin
        if (hit_any) begin
          new_row[hit_way*ENTRY_W] = 1'b0;
          do_write   = 1'b1;
          res_status = STAT_OK;
          res_obj    = rd_row[hit_way*ENTRY_W+1+COOKIE_W +: OBJECT_W];
          if (count != '0) begin
            count_next = count - 1'b1;
          end
        end
      end
      OP_LOOKUP: begin
        if (hit_any) begin
          res_status = STAT_OK;
          res_obj    = rd_row[hit_way*ENTRY_W+1+COOKIE_W +: OBJECT_W];
        end
      end
      default: begin
        res_status = STAT_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_cookie <= SEED_RESET;
      count       <= '0;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clr_we) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.cfg_we) begin
        next_cookie <= cfg_data;
      end else if (cmd.fire && (req_op == OP_INSERT) && free_any) begin
        next_cookie <= req_cookie;
      end
      if (cmd.fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op     <= opcode;
      req_obj    <= object_id;
      req_cookie <= key;
    end
    if (idx_done) begin
      row_addr <= idx;
    end
    if (cmd.fire) begin
      status     <= res_status;
      cookie_out <= res_cookie;
      object_out <= res_obj;
      live_count <= COUNT_W'(count_next);
    end
  end

  assign sts.clr_last = (clr_cnt == AW'(BUCKETS - 1));
  assign sts.idx_done = idx_done;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

// File: hdl/hct_ctrl.sv
// controller state machine: clearing pass, accept, index wait, evaluate
`timescale 1ns / 1ps
module hct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  hct_pkg::dp_status_t sts,
  output hct_pkg::ctrl_cmd_t  cmd
);
  import hct_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    cfg_ready  = (state == S_IDLE) || (state == S_CLEAR);
    cmd.cfg_we = cfg_valid && cfg_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // a seed write goes first, the request waits while cfg_valid is high
        in_stall = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.accept    = 1'b1;
          cmd.idx_start = 1'b1;
          // power-of-two bucket index is ready at once
          state_next = sts.idx_done ? S_EVAL : S_HASH;
        end
      end
      S_HASH: begin
        if (sts.idx_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.out_free) begin
          cmd.fire   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/handle_cookie_table_unit.sv
// top level of the handle cookie table
`timescale 1ns / 1ps
// timing: the request is taken, its bucket row read (after the 4-bit-per-cycle bucket
//   remainder when BUCKETS is not a power of two), then evaluated and the result registered
// throughput: a new request is taken only after the previous one has been evaluated and
//   written back; a stalled result output holds the evaluate state
// reset: synchronous; a clearing pass empties every bucket row with in_stall high,
//   the generator reloads 1 and the live count clears
module handle_cookie_table_unit #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hct_pkg::COOKIE_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hct_pkg::OP_W-1:0]        opcode,
  input  logic [hct_pkg::OBJECT_W-1:0]    object_id,
  input  logic [hct_pkg::COOKIE_W-1:0]    cookie_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hct_pkg::STAT_W-1:0]      status,
  output logic [hct_pkg::COOKIE_W-1:0]    cookie_out,
  output logic [hct_pkg::OBJECT_W-1:0]    object_out,
  output logic [hct_pkg::COUNT_W-1:0]     live_count
);
  import hct_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  hct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hct_datapath #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .object_id (object_id),
    .cookie_in (cookie_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cookie_out(cookie_out),
    .object_out(object_out),
    .live_count(live_count)
  );

endmodule

// File: tb/tb.sv
// self-checking testbench for the handle cookie table unit
`timescale 1ns / 1ps
module tb;
  import hct_pkg::*;

  localparam int TABLE_BUCKETS = 256;
  localparam int TABLE_WAYS    = 4;
  localparam int TABLE_SLOTS   = TABLE_BUCKETS * TABLE_WAYS;
  localparam int PHASES        = 8;
  localparam int PHASE_REQS    = 250;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;

  localparam logic [OP_W-1:0]     OP_UNUSED = 2'd3;
  localparam logic [COOKIE_W-1:0] ALL_ONES  = '1;
  // generator lands exactly on the all-ones cookie
  localparam logic [COOKIE_W-1:0] SEED_TOP  = 64'hFFFF_FFFF_FFFF_FFF8;
  // generator wraps to zero and has to step again
  localparam logic [COOKIE_W-1:0] SEED_WRAP = 64'hFFFF_FFFF_FFFF_FFF9;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [COOKIE_W-1:0] cookie;
    logic [OBJECT_W-1:0] obj;
    logic [COUNT_W-1:0]  live;
  } reply_t;

  typedef struct {
    bit                  load;
    logic [COOKIE_W-1:0] seed;
    logic [OP_W-1:0]     op;
    logic [OBJECT_W-1:0] oid;
    logic [COOKIE_W-1:0] ck;
    bit                  fixed;
    reply_t              want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COOKIE_W-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     opcode = OP_INSERT;
  logic [OBJECT_W-1:0] object_id = '0;
  logic [COOKIE_W-1:0] cookie_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [COOKIE_W-1:0] cookie_out;
  logic [OBJECT_W-1:0] object_out;
  logic [COUNT_W-1:0]  live_count;

  // table mirror
  bit                  slot_live [TABLE_SLOTS];
  logic [COOKIE_W-1:0] slot_ck   [TABLE_SLOTS];
  logic [OBJECT_W-1:0] slot_oid  [TABLE_SLOTS];
  logic [COOKIE_W-1:0] gen_cookie = SEED_RESET;
  int                  live_total = 0;

  reply_t              awaited_replies[$];
  logic [COOKIE_W-1:0] issued_cookies[$];
  plan_row_t           plan[$];

  int send_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;

  handle_cookie_table_unit #(
    .BUCKETS(TABLE_BUCKETS),
    .WAYS(TABLE_WAYS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .object_id(object_id),
    .cookie_in(cookie_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .cookie_out(cookie_out),
    .object_out(object_out),
    .live_count(live_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int bucket_base(input logic [COOKIE_W-1:0] ck);
    return int'(ck % COOKIE_W'(TABLE_BUCKETS)) * TABLE_WAYS;
  endfunction

  // applies one request to the mirror and returns the reply it should produce
  function automatic reply_t apply_table_op(input logic [OP_W-1:0] op,
                                            input logic [OBJECT_W-1:0] oid,
                                            input logic [COOKIE_W-1:0] ck);
    reply_t              r;
    logic [COOKIE_W-1:0] cand;
    int                  base;
    int                  slot;
    int                  w;
    r.status = STAT_NOT_FOUND;
    r.cookie = ck;
    r.obj    = '0;
    slot     = -1;
    if (op == OP_INSERT) begin
      cand = gen_cookie + COOKIE_STEP;
      if (cand == '0) cand = cand + COOKIE_STEP;
      base = bucket_base(cand);
      for (w = 0; w < TABLE_WAYS; w++)
        if (slot < 0 && !slot_live[base + w]) slot = base + w;
      if (slot >= 0) begin
        slot_live[slot] = 1'b1;
        slot_ck[slot]   = cand;
        slot_oid[slot]  = oid;
        gen_cookie      = cand;
        live_total++;
        r.status = STAT_OK;
        r.cookie = cand;
        issued_cookies.push_back(cand);
        if (issued_cookies.size() > 256) void'(issued_cookies.pop_front());
      end else begin
        r.status = STAT_FULL;
        r.cookie = '0;
      end
    end else if (op == OP_REMOVE || op == OP_LOOKUP) begin
      base = bucket_base(ck);
      // lowest matching way wins when cookies repeat after a seed reload
      for (w = 0; w < TABLE_WAYS; w++)
        if (slot < 0 && slot_live[base + w] && slot_ck[base + w] == ck) slot = base + w;
      if (slot >= 0) begin
        r.status = STAT_OK;
        r.obj    = slot_oid[slot];
        if (op == OP_REMOVE) begin
          slot_live[slot] = 1'b0;
          if (live_total > 0) live_total--;
        end
      end
    end
    r.live = COUNT_W'(live_total);
    return r;
  endfunction

  function automatic void plan_row(input bit load, input logic [COOKIE_W-1:0] seed,
                                   input logic [OP_W-1:0] op, input logic [OBJECT_W-1:0] oid,
                                   input logic [COOKIE_W-1:0] ck, input bit fixed,
                                   input logic [STAT_W-1:0] st, input logic [COOKIE_W-1:0] wck,
                                   input logic [OBJECT_W-1:0] woid,
                                   input logic [COUNT_W-1:0] wlive);
    plan_row_t p;
    p.load  = load;
    p.seed  = seed;
    p.op    = op;
    p.oid   = oid;
    p.ck    = ck;
    p.fixed = fixed;
    p.want  = '{status: st, cookie: wck, obj: woid, live: wlive};
    plan.push_back(p);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [OP_W-1:0] op, input logic [OBJECT_W-1:0] oid,
                          input logic [COOKIE_W-1:0] ck, input bit fixed, input reply_t typed);
    reply_t predicted;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    object_id <= oid;
    cookie_in <= ck;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_table_op(op, oid, ck);
    awaited_replies.push_back(fixed ? typed : predicted);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_seed(input logic [COOKIE_W-1:0] seed);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= seed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gen_cookie = seed;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("result with nothing outstanding: status %0d cookie %h", status, cookie_out);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (cookie_out !== want.cookie) begin
          $error("cookie_out: expected %h, got %h", want.cookie, cookie_out);
          fail_count++;
        end
        if (object_out !== want.obj) begin
          $error("object_out: expected %h, got %h", want.obj, object_out);
          fail_count++;
        end
        if (live_count !== want.live) begin
          $error("live_count: expected %0d, got %0d", want.live, live_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [COOKIE_W-1:0] base_seed;
    logic [COOKIE_W-1:0] ck;
    logic [OBJECT_W-1:0] oid;
    logic [OP_W-1:0]     op;
    int                  pick;

    plan_row(0, '0, OP_INSERT, 16'h0000, '0, 1, STAT_OK, 64'd8, '0, 11'd1);
    plan_row(0, '0, OP_INSERT, 16'hFFFF, ALL_ONES, 1, STAT_OK, 64'd15, '0, 11'd2);
    plan_row(0, '0, OP_LOOKUP, 16'h0000, 64'd8, 1, STAT_OK, 64'd8, 16'h0000, 11'd2);
    plan_row(0, '0, OP_LOOKUP, 16'h0000, 64'd15, 1, STAT_OK, 64'd15, 16'hFFFF, 11'd2);
    // zero cookie never matches
    plan_row(0, '0, OP_LOOKUP, 16'hFFFF, '0, 1, STAT_NOT_FOUND, '0, '0, 11'd2);
    plan_row(0, '0, OP_REMOVE, 16'h0000, ALL_ONES, 1, STAT_NOT_FOUND, ALL_ONES, '0, 11'd2);
    plan_row(0, '0, OP_UNUSED, 16'hFFFF, 64'd8, 1, STAT_NOT_FOUND, 64'd8, '0, 11'd2);
    plan_row(0, '0, OP_REMOVE, 16'h0000, 64'd8, 1, STAT_OK, 64'd8, 16'h0000, 11'd1);
    plan_row(0, '0, OP_REMOVE, 16'h0000, 64'd8, 1, STAT_NOT_FOUND, 64'd8, '0, 11'd1);
    plan_row(1, SEED_TOP, OP_INSERT, 16'h1234, '0, 1, STAT_OK, ALL_ONES, '0, 11'd2);
    plan_row(0, '0, OP_INSERT, 16'h5678, '0, 1, STAT_OK, 64'd6, '0, 11'd3);
    plan_row(1, SEED_WRAP, OP_INSERT, 16'hA5A5, '0, 1, STAT_OK, 64'd7, '0, 11'd4);
    // same seed again: duplicate cookies pile into one bucket until it is full
    plan_row(1, '0, OP_INSERT, 16'h0001, '0, 1, STAT_OK, 64'd7, '0, 11'd5);
    plan_row(1, '0, OP_INSERT, 16'h0002, '0, 0, STAT_OK, '0, '0, '0);
    plan_row(1, '0, OP_INSERT, 16'h0003, '0, 0, STAT_OK, '0, '0, '0);
    plan_row(1, '0, OP_INSERT, 16'h0004, '0, 1, STAT_FULL, '0, '0, 11'd7);
    plan_row(0, '0, OP_LOOKUP, 16'h0000, 64'd7, 0, STAT_OK, '0, '0, '0);
    plan_row(0, '0, OP_REMOVE, 16'h0000, 64'd7, 0, STAT_OK, '0, '0, '0);
    plan_row(0, '0, OP_LOOKUP, 16'h0000, 64'd7, 0, STAT_OK, '0, '0, '0);
    plan_row(0, '0, OP_INSERT, 16'h8000, '0, 0, STAT_OK, '0, '0, '0);
    plan_row(0, '0, OP_LOOKUP, 16'h0000, 64'd6, 0, STAT_OK, '0, '0, '0);
    plan_row(0, '0, OP_LOOKUP, 16'h0000, ALL_ONES, 0, STAT_OK, '0, '0, '0);
    plan_row(1, ALL_ONES, OP_INSERT, 16'h7FFF, '0, 0, STAT_OK, '0, '0, '0);
    plan_row(0, '0, OP_REMOVE, 16'h0000, 64'd6, 0, STAT_OK, '0, '0, '0);
    plan_row(0, '0, OP_REMOVE, 16'h0000, 64'd15, 0, STAT_OK, '0, '0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].load) load_seed(plan[i].seed);
      send_req(plan[i].op, plan[i].oid, plan[i].ck, plan[i].fixed, plan[i].want);
    end

    base_seed = {$urandom, $urandom};
    for (int p = 0; p < PHASES; p++) begin
      // reusing one seed re-issues the same cookies, so buckets fill and repeat
      load_seed((p % 3 == 2) ? {$urandom, $urandom} : base_seed);
      case (p % 4)
        0: begin
          send_pct  <= 0;
          stall_pct <= 0;
        end
        1: begin
          send_pct  <= 57;
          stall_pct <= 0;
        end
        2: begin
          send_pct  <= 0;
          stall_pct <= 57;
        end
        default: begin
          send_pct  <= 8;
          stall_pct <= 8;
        end
      endcase
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (p == 0 && i == PHASE_REQS / 2) hold_left <= HOLD_CYCLES;
        if (p == 1 && i == PHASE_REQS / 2) wait_drained();
        pick = $urandom_range(99);
        oid  = OBJECT_W'($urandom);
        ck   = {$urandom, $urandom};
        op   = OP_LOOKUP;
        if (pick < 40) begin
          op = OP_INSERT;
        end else if (pick < 85 && issued_cookies.size() > 0) begin
          ck = issued_cookies[$urandom_range(issued_cookies.size() - 1)];
          op = (pick < 65) ? OP_LOOKUP : OP_REMOVE;
        end else if (pick < 91) begin
          op = $urandom_range(1) ? OP_REMOVE : OP_LOOKUP;
        end else if (pick < 94) begin
          op = OP_UNUSED;
        end else if (pick < 97) begin
          ck = '0;
          op = $urandom_range(1) ? OP_REMOVE : OP_LOOKUP;
        end else if (issued_cookies.size() > 0) begin
          // near miss: one bit off a cookie that was handed out
          ck = issued_cookies[$urandom_range(issued_cookies.size() - 1)]
               ^ (64'd1 << $urandom_range(63));
        end
        send_req(op, oid, ck, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/hct_pkg.sv
hdl/hct_ram.sv
hdl/hct_bucket_rem.sv
hdl/hct_datapath.sv
hdl/hct_ctrl.sv
hdl/handle_cookie_table_unit.sv
tb/tb.sv
